FILE: sv/assert_macros.svh
// assertion helper macros used by the top-level rtl file
// no dependencies; each macro checks one implication at the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define CHK_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while reset is high
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/ipse_pkg.sv
// shared types, constants and helpers for the stack engine
// used by the controller, the datapath, the divider and the top level
package ipse_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [31:0] VAL_EMPTY = 32'hFFFF_FFFF;

   localparam logic MODE_CONVERT = 1'b0;
   localparam logic MODE_EVAL    = 1'b1;

   typedef enum logic [1:0] {
      PS_CHAR,
      PS_DIGIT,
      PS_RES
   } push_sel_type;

   typedef enum logic [1:0] {
      EM_CHAR,
      EM_TOPCH,
      EM_VAL
   } emit_sel_type;

   typedef struct packed {
      logic         load;
      logic         push;
      push_sel_type push_sel;
      logic         pop;
      logic         pop_b;
      logic         pop_a;
      logic         exec;
      logic         emit;
      emit_sel_type emit_sel;
      logic         finish;
      logic         clear;
   } cmd_type;

   typedef struct packed {
      logic             mode;
      logic             is_op;
      logic             count_nz;
      logic             top_ge;
      logic             last;
      logic             emit_ok;
      logic             div_needed;
      logic             div_done;
      logic             pend_valid;
      logic [CNT_W-1:0] count;
   } status_type;

   function automatic logic is_op_f(input logic [31:0] c);
      return c == {24'd0, CH_PLUS} || c == {24'd0, CH_MINUS} ||
             c == {24'd0, CH_MUL} || c == {24'd0, CH_DIV};
   endfunction

   function automatic logic [1:0] rank_f(input logic [31:0] c);
      logic [1:0] r;
      r = 2'd0;
      if (c == {24'd0, CH_PLUS} || c == {24'd0, CH_MINUS})
         r = 2'd1;
      else if (c == {24'd0, CH_MUL} || c == {24'd0, CH_DIV})
         r = 2'd2;
      return r;
   endfunction

endpackage

FILE: sv/infix_postfix_stack_engine_unit.sv
// top level of the infix-to-postfix converter and postfix evaluator
// depends on ipse_pkg, ipse_ctrl, ipse_dpath (with ipse_div) and assert_macros.svh
//
// usage:
// - req channel takes one expression character per beat, tlast on the final one
// - csr channel writes the mode bit (0 convert, 1 evaluate); write it only when idle
// - rsp channel returns zero to three results per character; tlast marks the
//   last result a character causes, a character may cause none
// - one character at a time; no new character is taken until the last is finished,
//   and a divide waits on the one-bit-per-cycle divider
// - a stack change before a top read is followed by a wait for the registered read
// - reset empties the stack, clears the sticky flags and selects convert mode;
//   the stack memory itself is not cleared, entries above the top are never used
// - a stalled rsp side holds the output register; one more result waits in the
//   staging register, after that the engine waits and req_tready stays low
`include "assert_macros.svh"

module infix_postfix_stack_engine_unit
   import ipse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tlast,   // last character of the expression
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] out_char, [39:8] value, [40] overflow,
                                    // [41] div_zero, [47:42] zero
   output logic        rsp_tlast,   // end_of_run
   // mode register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // mode
);

   cmd_type    cmd;
   status_type status;

   // mode writes are taken at any time
   assign csr_ready = 1'b1;

   ipse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ipse_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a beat taken means the engine is busy on the next cycle
   `CHK_NEXT(a_busy_after_beat, req_tvalid && req_tready, !req_tready, "ready after accept")
   // stack pointer never passes the depth
   `CHK_SAME(a_count_bound, 1'b1, status.count <= CNT_W'(STACK_DEPTH), "stack count overrun")
   // no result may sit in staging while idle, else its tlast would be lost
   `CHK_SAME(a_idle_no_pend, req_tready, !status.pend_valid, "staged result left behind")

endmodule

FILE: sv/ipse_div.sv
// iterative signed 32-bit divider, one quotient bit per cycle
// depends on ipse_pkg only by convention; truncates toward zero
module ipse_div
   import ipse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] d_ff, d_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   assign shifted = {rem_ff[31:0], quo_ff[31]};
   assign diff    = shifted - {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[31] ^ divisor[31];
         cnt_in  = 6'd32;
         rem_in  = 33'd0;
         quo_in  = dividend[31] ? (~dividend + 32'd1) : dividend;
         d_in    = divisor[31] ? (~divisor + 32'd1) : divisor;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      d_ff   <= d_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 32'd1) : quo_ff;

endmodule

FILE: sv/ipse_dpath.sv
// datapath: stack memory, operand registers, alu, result staging and output register
// depends on ipse_pkg and ipse_div; driven by commands from ipse_ctrl
module ipse_dpath
   import ipse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        csr_valid,
   input  logic        csr_data,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast
);

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] top_ff;
   logic [IDX_W-1:0] top_idx;

   logic             mode_ff;
   logic [7:0]       char_ff;
   logic             last_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             dz_ff, dz_in;
   logic [31:0]      a_ff, b_ff, res_ff;

   logic             pend_valid_ff, pend_valid_in;
   logic [7:0]       pend_char_ff;
   logic [31:0]      pend_val_ff;
   logic             pend_ovf_ff, pend_dz_ff;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_char_ff;
   logic [31:0]      out_val_ff;
   logic             out_ovf_ff, out_dz_ff, out_last_ff;

   logic        count_nz;
   logic        full;
   logic [31:0] push_val;
   logic [31:0] top_or_empty;
   logic [7:0]  new_char;
   logic [31:0] new_val;
   logic        out_free;
   logic        div_start;
   logic        div_done;
   logic [31:0] div_q;

   assign count_nz     = count_ff != '0;
   assign full         = count_ff == CNT_W'(STACK_DEPTH);
   assign top_idx      = IDX_W'(count_ff - CNT_W'(1));
   assign top_or_empty = count_nz ? top_ff : VAL_EMPTY;
   assign out_free     = !out_valid_ff || rsp_tready;
   assign div_start    = cmd.exec && char_ff == CH_DIV && b_ff != 32'd0;

   always_comb begin
      case (cmd.push_sel)
         PS_CHAR:  push_val = {24'd0, char_ff};
         PS_DIGIT: push_val = {24'd0, char_ff} - {24'd0, CH_ZERO};
         PS_RES:   push_val = res_ff;
         default:  push_val = res_ff;
      endcase
   end

   always_comb begin
      case (cmd.emit_sel)
         EM_CHAR: begin
            new_char = char_ff;
            new_val  = 32'd0;
         end
         EM_TOPCH: begin
            new_char = top_ff[7:0];
            new_val  = 32'd0;
         end
         EM_VAL: begin
            new_char = 8'd0;
            new_val  = top_or_empty;
         end
         default: begin
            new_char = 8'd0;
            new_val  = 32'd0;
         end
      endcase
   end

   // stack pointer and sticky flags
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      dz_in    = dz_ff;
      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
         dz_in    = 1'b0;
      end else if (cmd.push) begin
         if (full)
            ovf_in = 1'b1;
         else
            count_in = count_ff + CNT_W'(1);
      end else if ((cmd.pop || cmd.pop_a || cmd.pop_b) && count_nz) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.exec && char_ff == CH_DIV && b_ff == 32'd0)
         dz_in = 1'b1;
   end

   // staging register holds one result back so the final one can carry tlast
   always_comb begin
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (cmd.emit) begin
         pend_valid_in = 1'b1;
         if (pend_valid_ff)
            out_valid_in = 1'b1;
      end else if (cmd.finish && pend_valid_ff) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CONVERT;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         dz_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid)
            mode_ff <= csr_data;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         dz_ff         <= dz_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= mem[top_idx];
      if (cmd.push && !full)
         mem[IDX_W'(count_ff)] <= push_val;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (cmd.pop_b)
         b_ff <= top_or_empty;
      if (cmd.pop_a)
         a_ff <= top_or_empty;
      if (cmd.exec) begin
         case (char_ff)
            CH_PLUS:  res_ff <= a_ff + b_ff;
            CH_MINUS: res_ff <= a_ff - b_ff;
            CH_MUL:   res_ff <= a_ff * b_ff;
            default:  res_ff <= 32'd0;
         endcase
      end else if (div_done) begin
         res_ff <= div_q;
      end
      if (cmd.emit) begin
         pend_char_ff <= new_char;
         pend_val_ff  <= new_val;
         pend_ovf_ff  <= ovf_ff;
         pend_dz_ff   <= dz_ff;
      end
      if ((cmd.emit || cmd.finish) && pend_valid_ff) begin
         out_char_ff <= pend_char_ff;
         out_val_ff  <= pend_val_ff;
         out_ovf_ff  <= pend_ovf_ff;
         out_dz_ff   <= pend_dz_ff;
         out_last_ff <= cmd.finish;
      end
   end

   ipse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      status.mode       = mode_ff;
      status.is_op      = is_op_f({24'd0, char_ff});
      status.count_nz   = count_nz;
      status.top_ge     = rank_f(top_ff) >= rank_f({24'd0, char_ff});
      status.last       = last_ff;
      status.emit_ok    = !pend_valid_ff || out_free;
      status.div_needed = char_ff == CH_DIV && b_ff != 32'd0;
      status.div_done   = div_done;
      status.pend_valid = pend_valid_ff;
      status.count      = count_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_dz_ff, out_ovf_ff, out_val_ff, out_char_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: sv/ipse_ctrl.sv
// controller: sequences one character through stack, alu and output staging
// depends on ipse_pkg; talks to ipse_dpath through cmd_type and status_type
module ipse_ctrl
   import ipse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_WAIT,
      S_DECIDE,
      S_CV_LOOP,
      S_CV_SET,
      S_PSET,
      S_TAIL,
      S_FSET,
      S_POPB,
      S_WB,
      S_POPA,
      S_EXEC,
      S_DIV,
      S_PUSHR,
      S_FIN
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] n_ff, n_in;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      cmd      = '0;
      cmd.push_sel = PS_CHAR;
      cmd.emit_sel = EM_CHAR;
      case (state_ff)
         S_IDLE: begin
            n_in = 2'd0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: state_in = S_DECIDE;
         S_DECIDE: begin
            if (status.mode == MODE_CONVERT) begin
               if (status.is_op) begin
                  state_in = S_CV_LOOP;
               end else if (status.emit_ok) begin
                  cmd.emit = 1'b1;
                  cmd.emit_sel = EM_CHAR;
                  n_in = 2'd1;
                  state_in = S_TAIL;
               end
            end else begin
               if (status.is_op) begin
                  state_in = S_POPB;
               end else begin
                  cmd.push = 1'b1;
                  cmd.push_sel = PS_DIGIT;
                  state_in = S_PSET;
               end
            end
         end
         S_CV_LOOP: begin
            if (status.count_nz && status.top_ge && n_ff < 2'd2) begin
               if (status.emit_ok) begin
                  cmd.emit = 1'b1;
                  cmd.emit_sel = EM_TOPCH;
                  cmd.pop = 1'b1;
                  n_in = n_ff + 2'd1;
                  state_in = S_CV_SET;
               end
            end else begin
               cmd.push = 1'b1;
               cmd.push_sel = PS_CHAR;
               state_in = S_PSET;
            end
         end
         S_CV_SET: state_in = S_CV_LOOP;
         S_PSET:   state_in = S_TAIL;
         S_TAIL: begin
            if (!status.last) begin
               state_in = S_FIN;
            end else if (status.mode == MODE_CONVERT) begin
               if (status.count_nz && n_ff != 2'd3) begin
                  if (status.emit_ok) begin
                     cmd.emit = 1'b1;
                     cmd.emit_sel = EM_TOPCH;
                     cmd.pop = 1'b1;
                     n_in = n_ff + 2'd1;
                     state_in = S_FSET;
                  end
               end else begin
                  state_in = S_FIN;
               end
            end else if (status.emit_ok) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = EM_VAL;
               state_in = S_FIN;
            end
         end
         S_FSET: state_in = S_TAIL;
         S_POPB: begin
            cmd.pop_b = 1'b1;
            state_in = S_WB;
         end
         S_WB: state_in = S_POPA;
         S_POPA: begin
            cmd.pop_a = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.div_needed ? S_DIV : S_PUSHR;
         end
         S_DIV: begin
            if (status.div_done)
               state_in = S_PUSHR;
         end
         S_PUSHR: begin
            cmd.push = 1'b1;
            cmd.push_sel = PS_RES;
            state_in = S_PSET;
         end
         S_FIN: begin
            if (status.emit_ok) begin
               cmd.finish = 1'b1;
               cmd.clear = status.last;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the infix/postfix stack engine
// depends on ipse_pkg and infix_postfix_stack_engine_unit
module tb_top
   import ipse_pkg::*;
();

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;

   typedef struct packed {
      logic [7:0]  out_char;
      logic [31:0] value;
      logic        end_of_run;
      logic        overflow;
      logic        div_zero;
   } result_type;

   // predictor state
   logic [31:0] stk [STACK_DEPTH];
   int          depth;
   logic        ovf_flag;
   logic        dz_flag;
   logic        cur_mode;

   result_type  pending_results[$];
   int          error_count;
   longint      cycle_count;
   int          hold_cycles;

   localparam longint CYCLE_LIMIT = 2000000;

   infix_postfix_stack_engine_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic is_operator(logic [31:0] c);
      return c == {24'd0, CH_PLUS} || c == {24'd0, CH_MINUS} ||
             c == {24'd0, CH_MUL} || c == {24'd0, CH_DIV};
   endfunction

   function automatic int precedence(logic [31:0] c);
      if (c == {24'd0, CH_PLUS} || c == {24'd0, CH_MINUS}) return 1;
      if (c == {24'd0, CH_MUL} || c == {24'd0, CH_DIV}) return 2;
      return 0;
   endfunction

   function automatic void stack_push(logic [31:0] v);
      if (depth >= STACK_DEPTH) ovf_flag = 1'b1;
      else begin
         stk[depth] = v;
         depth++;
      end
   endfunction

   function automatic logic [31:0] stack_pop();
      if (depth == 0) return VAL_EMPTY;
      depth--;
      return stk[depth];
   endfunction

   function automatic logic [31:0] arith(logic [7:0] op, logic [31:0] a, logic [31:0] b);
      case (op)
         CH_PLUS:  return a + b;
         CH_MINUS: return a - b;
         CH_MUL:   return a * b;
         default: begin
            if (b == 0) begin
               dz_flag = 1'b1;
               return 32'd0;
            end
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'h8000_0000;
            return $signed(a) / $signed(b);
         end
      endcase
   endfunction

   function automatic void emit_result(logic [7:0] ch, logic [31:0] v);
      result_type r;
      r.out_char   = ch;
      r.value      = v;
      r.end_of_run = 1'b0;
      r.overflow   = ovf_flag;
      r.div_zero   = dz_flag;
      pending_results.push_back(r);
   endfunction

   // work out the results of one character
   function automatic void predict_char(logic [7:0] c, logic lst);
      int n;
      logic [31:0] a, b;
      n = 0;
      if (cur_mode == MODE_CONVERT) begin
         if (!is_operator({24'd0, c})) begin
            emit_result(c, 32'd0);
            n++;
         end else begin
            while (depth > 0 && precedence(stk[depth-1]) >= precedence({24'd0, c})
                   && n < 2) begin
               emit_result(8'(stack_pop()), 32'd0);
               n++;
            end
            stack_push({24'd0, c});
         end
         if (lst)
            while (depth > 0 && n < 3) begin
               emit_result(8'(stack_pop()), 32'd0);
               n++;
            end
      end else begin
         if (!is_operator({24'd0, c})) stack_push({24'd0, c} - {24'd0, CH_ZERO});
         else begin
            b = stack_pop();
            a = stack_pop();
            stack_push(arith(c, a, b));
         end
         if (lst) begin
            emit_result(8'd0, depth > 0 ? stk[depth-1] : VAL_EMPTY);
            n++;
         end
      end
      if (n > 0) pending_results[$].end_of_run = 1'b1;
      if (lst) begin
         depth    = 0;
         ovf_flag = 1'b0;
         dz_flag  = 1'b0;
      end
   endfunction

   // send one character beat, bursty sender; valid stays up between beats of a burst
   task automatic send_char(logic [7:0] c, logic lst);
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_char(c, lst);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_mode(logic m);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_mode = m;
   endtask

   task automatic send_string(string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == s.len() - 1);
   endtask

   // directed convert: both ranks, non-operators at extremes, flush
   task automatic test_convert_directed();
      write_mode(MODE_CONVERT);
      send_string("a+b*c-d/e");
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(CH_MUL, 1'b0);
      send_char(CH_PLUS, 1'b1);
      // operator on empty stack, not last: no result
      send_char(CH_MINUS, 1'b0);
      send_char(8'h41, 1'b1);
   endtask

   // directed evaluate: every operation, empty pops, divide by zero, wrap
   task automatic test_eval_directed();
      write_mode(MODE_EVAL);
      send_string("93-4*2/");
      send_string("50/");
      send_string("+");
      send_char(CH_PLUS, 1'b0);
      send_char(CH_DIV, 1'b1);
      send_string("8");
      send_char(8'h00, 1'b0);   // -48
      send_char(8'hFF, 1'b1);   // 207
      // most negative over -1: 8^10 * 2 wraps to 0x80000000, 0 - 1 gives -1
      send_char(8'h38, 1'b0);
      for (int i = 0; i < 9; i++) begin
         send_char(8'h38, 1'b0);
         send_char(CH_MUL, 1'b0);
      end
      send_char(8'h32, 1'b0);
      send_char(CH_MUL, 1'b0);
      send_string("01-/");
   endtask

   task automatic test_overflow();
      write_mode(MODE_EVAL);
      for (int i = 0; i < STACK_DEPTH + 2; i++) send_char(8'h37, 1'b0);
      send_char(CH_MUL, 1'b1);
   endtask

   // mode switch with stack left over, then long receiver hold-off
   task automatic test_mode_switch_and_pressure();
      write_mode(MODE_EVAL);
      send_string("12");
      send_char(8'h33, 1'b0);
      write_mode(MODE_CONVERT);
      hold_cycles = 400;
      send_char(CH_PLUS, 1'b1);
      for (int i = 0; i < 12; i++) send_char(8'(8'h61 + i), i == 11);
   endtask

   function automatic logic [7:0] rand_operator();
      case ($urandom_range(0, 3))
         0: return CH_PLUS;
         1: return CH_MINUS;
         2: return CH_MUL;
         default: return CH_DIV;
      endcase
   endfunction

   task automatic test_random(int items);
      int sent, len;
      logic [7:0] c;
      sent = 0;
      while (sent < items) begin
         write_mode(1'($urandom_range(0, 1)));
         for (int e = 0; e < 6 && sent < items; e++) begin
            len = $urandom_range(1, 5);
            if ($urandom_range(0, 7) == 0) begin
               // noise
               for (int i = 0; i < len; i++) begin
                  c = 8'($urandom_range(0, 255));
                  send_char(c, i == len - 1);
                  sent++;
               end
            end else if (cur_mode == MODE_EVAL) begin
               send_char(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
               for (int i = 0; i < len; i++) begin
                  send_char(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
                  send_char(rand_operator(), i == len - 1);
                  sent += 2;
               end
               sent++;
            end else begin
               for (int i = 0; i < len; i++) begin
                  send_char(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
                  send_char(rand_operator(), 1'b0);
                  sent += 2;
               end
               send_char(8'(8'h61 + $urandom_range(0, 25)), 1'b1);
               sent++;
            end
         end
      end
   endtask

   // receiver stall pattern plus optional long hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (cycle_count[9:7] == 3'd2)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // result checker
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat %h", rsp_tdata);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tdata[7:0] !== exp_r.out_char) begin
               $error("out_char exp %h got %h", exp_r.out_char, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[39:8] !== exp_r.value) begin
               $error("value exp %h got %h", exp_r.value, rsp_tdata[39:8]);
               error_count++;
            end
            if (rsp_tdata[40] !== exp_r.overflow) begin
               $error("overflow exp %b got %b", exp_r.overflow, rsp_tdata[40]);
               error_count++;
            end
            if (rsp_tdata[41] !== exp_r.div_zero) begin
               $error("div_zero exp %b got %b", exp_r.div_zero, rsp_tdata[41]);
               error_count++;
            end
            if (rsp_tlast !== exp_r.end_of_run) begin
               $error("end_of_run exp %b got %b", exp_r.end_of_run, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'd0;
      req_tlast   = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = 1'b0;
      rsp_tready  = 1'b0;
      hold_cycles = 0;
      cycle_count = 0;
      error_count = 0;
      depth       = 0;
      ovf_flag    = 1'b0;
      dz_flag     = 1'b0;
      cur_mode    = MODE_CONVERT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_convert_directed();
      test_eval_directed();
      test_overflow();
      test_mode_switch_and_pressure();
      test_random(300);
      wait_drained();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
